### rtl/spa_pkg.sv
// Shared types and constants for the saturating pixel accumulator.
package spa_pkg;

   // Fixed field widths of the request and result items
   localparam int COORD_W = 8;
   localparam int ADD_W   = 16;
   localparam int PIXEL_W = 16;
   localparam int REQ_W   = 2;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_ACCUMULATE = 2'd0;
   localparam logic [REQ_W-1:0] REQ_CLEAR      = 2'd1;
   localparam logic [REQ_W-1:0] REQ_READ       = 2'd2;

   // One request item
   typedef struct packed {
      logic [REQ_W-1:0]   req_type;
      logic [COORD_W-1:0] pixel_row;
      logic [COORD_W-1:0] pixel_col;
      logic [ADD_W-1:0]   add_value;
   } spa_req_type;

   // One result item
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_value;
      logic               clipped;
   } spa_rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;        // latch the request, rewind the sweep counter
      logic lookup;        // read the addressed pixel
      logic update;        // write back the new count on accumulate, load the result
      logic sweep;         // write zero at the sweep counter, advance it
      logic respond_zero;  // load an all-zero result
   } spa_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_clear;
      logic is_pixel_op;   // accumulate or read
      logic in_range;
      logic sweep_last;
   } spa_status_type;

endpackage

### rtl/saturating_pixel_accumulator_core.sv
// Top level of the saturating pixel accumulator: controller plus datapath.
//
// Keeps a MAP_ROWS x MAP_COLS map of COUNT_BITS-wide pixel counts in one
// RAM. An item is taken at a clock edge with start high and busy low. An
// accumulate or a read passes through a lookup state that addresses the
// RAM, an update state that gets the registered read data and, for an
// accumulate, writes back the saturated sum, and the result strobe, during
// which busy is already low. The result of an accumulate or read shows on
// rsp_item with rsp_strobe high for one cycle, from the result register
// loaded in the update state; the receiver cannot stall it. A clear walks
// the RAM writing one pixel per cycle, holds busy through the lookup and the
// sweep, and then sends a zero result. After reset the same sweep runs with
// busy high and sends no result. Unused request codes and addresses outside
// the map give a zero result without touching the map.
module saturating_pixel_accumulator_core #(
   parameter int MAP_ROWS   = 256,
   parameter int MAP_COLS   = 256,
   parameter int COUNT_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  spa_pkg::spa_req_type req_item,
   output logic                 rsp_strobe,
   output spa_pkg::spa_rsp_type rsp_item
);
   import spa_pkg::*;

   spa_cmd_type    cmd;
   spa_status_type status;

   // Sequencing
   spa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   // Count map and arithmetic
   spa_datapath #(
      .MAP_ROWS   (MAP_ROWS),
      .MAP_COLS   (MAP_COLS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_item   (req_item),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

### rtl/spa_ram.sv
// Generic single write port, single read port RAM with registered read.
module spa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/spa_ctrl.sv
// Controller state machine: request sequencing and the map clearing sweep.
module spa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output spa_pkg::spa_cmd_type    cmd,
   input  spa_pkg::spa_status_type status
);
   import spa_pkg::*;

   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_LOOKUP = 2'd2;
   localparam logic [1:0] S_UPDATE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       reply_ff, reply_in;   // clear came from a request, not reset
   logic       accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      reply_in = reply_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               cmd.respond_zero = reply_ff;
               reply_in         = 1'b0;
               state_in         = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               state_in   = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            if (status.is_clear) begin
               reply_in = 1'b1;
               state_in = S_CLEAR;
            end else if (status.is_pixel_op && status.in_range) begin
               cmd.lookup = 1'b1;
               state_in   = S_UPDATE;
            end else begin
               cmd.respond_zero = 1'b1;
               state_in         = S_IDLE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers; reset starts with a sweep that sends no result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         reply_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         reply_ff <= reply_in;
      end
   end

   // An accepted item is always looked at in the following cycle
   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_LOOKUP))
      else $error("accepted item did not move to lookup");

   // Write-back only ever follows the lookup that issued the read
   a_update_after_lookup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) |-> ($past(state_ff) == S_LOOKUP))
      else $error("update without a preceding lookup");

   // Write-back only touches a pixel inside the map
   a_update_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) |-> (status.in_range && status.is_pixel_op))
      else $error("update for an out-of-range or non-pixel request");

endmodule

### rtl/spa_datapath.sv
// Datapath: request register, address math, count map, saturating add, result register.
module spa_datapath #(
   parameter int MAP_ROWS   = 256,
   parameter int MAP_COLS   = 256,
   parameter int COUNT_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  spa_pkg::spa_cmd_type    cmd,
   input  spa_pkg::spa_req_type    req_item,
   output spa_pkg::spa_status_type status,
   output logic                    rsp_strobe,
   output spa_pkg::spa_rsp_type    rsp_item
);
   import spa_pkg::*;

   localparam int DEPTH  = MAP_ROWS * MAP_COLS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SUM_W  = ((COUNT_BITS > ADD_W) ? COUNT_BITS : ADD_W) + 1;

   spa_req_type          req_ff;
   logic [ADDR_W-1:0]    sweep_cnt_ff, sweep_cnt_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   spa_rsp_type          rsp_ff, rsp_in;

   logic [ADDR_W-1:0]     pix_addr;
   logic [COUNT_BITS-1:0] rd_count;
   logic [SUM_W-1:0]      sum;
   logic [SUM_W-1:0]      sum_max;
   logic                  clip;
   logic [COUNT_BITS-1:0] new_count;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [COUNT_BITS-1:0] wr_data;

   // Request register
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_item;
      end
   end

   // Decode and range check of the held request
   assign status.is_clear    = (req_ff.req_type == REQ_CLEAR);
   assign status.is_pixel_op = (req_ff.req_type == REQ_ACCUMULATE) ||
                               (req_ff.req_type == REQ_READ);
   assign status.in_range    = (32'(req_ff.pixel_row) < 32'(MAP_ROWS)) &&
                               (32'(req_ff.pixel_col) < 32'(MAP_COLS));
   assign status.sweep_last  = (sweep_cnt_ff == ADDR_W'(DEPTH - 1));

   // Linear pixel address, row major
   assign pix_addr = ADDR_W'(ADDR_W'(req_ff.pixel_row) * ADDR_W'(MAP_COLS))
                   + ADDR_W'(req_ff.pixel_col);

   // Saturating add against the stored count
   assign sum_max   = SUM_W'({COUNT_BITS{1'b1}});
   assign sum       = SUM_W'(rd_count) + SUM_W'(req_ff.add_value);
   assign clip      = (sum > sum_max);
   assign new_count = clip ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];

   // Single write port: sweep writes zero, accumulate writes the new count
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pix_addr;
      wr_data = new_count;
      if (cmd.sweep) begin
         wr_en   = 1'b1;
         wr_addr = sweep_cnt_ff;
         wr_data = '0;
      end else if (cmd.update && (req_ff.req_type == REQ_ACCUMULATE)) begin
         wr_en = 1'b1;
      end
   end

   spa_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.lookup),
      .rd_addr (pix_addr),
      .rd_data (rd_count)
   );

   // Sweep counter
   always_comb begin
      sweep_cnt_in = sweep_cnt_ff;
      if (cmd.accept) begin
         sweep_cnt_in = '0;
      end else if (cmd.sweep) begin
         sweep_cnt_in = sweep_cnt_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
      end else begin
         sweep_cnt_ff <= sweep_cnt_in;
      end
   end

   // Result item: new sum on accumulate, stored count on read, zero otherwise
   always_comb begin
      rsp_strobe_in = cmd.update || cmd.respond_zero;
      rsp_in        = '0;
      if (cmd.update) begin
         if (req_ff.req_type == REQ_ACCUMULATE) begin
            rsp_in.pixel_value = PIXEL_W'(new_count);
            rsp_in.clipped     = clip;
         end else begin
            rsp_in.pixel_value = PIXEL_W'(rd_count);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_strobe_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule
